// ===== sv/sem_pkg.sv =====
// ----------------------------------------------------------------------------
// sem_pkg
// Shared types and constants for the RGB Sobel edge magnitude unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sem_pkg;

   localparam int CHAN_N     = 3;
   localparam int CHAN_W     = 8;
   localparam int PIX_W      = CHAN_N * CHAN_W;
   localparam int WIN_N      = 3;
   localparam int TAPS       = WIN_N * WIN_N;
   localparam int KERN_BITS  = 3;
   localparam int GRAD_W     = 11;
   localparam int SAT_LIMIT  = ((1 << CHAN_W) - 1) << CHAN_W;

   localparam int IMG_W_BITS = 11;
   localparam int IMG_H_BITS = 13;
   localparam logic [IMG_W_BITS-1:0] IMG_W_RESET = 11'd640;
   localparam logic [IMG_H_BITS-1:0] IMG_H_RESET = 13'd480;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

   localparam logic signed [KERN_BITS-1:0] KERN_X [TAPS] = '{
      -3'sd1, 3'sd0, 3'sd1,
      -3'sd2, 3'sd0, 3'sd2,
      -3'sd1, 3'sd0, 3'sd1
   };
   localparam logic signed [KERN_BITS-1:0] KERN_Y [TAPS] = '{
      -3'sd1, -3'sd2, -3'sd1,
       3'sd0,  3'sd0,  3'sd0,
       3'sd1,  3'sd2,  3'sd1
   };

   // channel 0 is red, 1 green, 2 blue
   typedef logic [CHAN_N-1:0][CHAN_W-1:0] rgb_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] blue_in;
      logic              flush;
   } sem_req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] red_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] blue_out;
      logic              frame_last;
   } sem_rsp_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } sem_csr_type;

   typedef struct packed {
      logic top;
      logic bottom;
      logic left;
      logic right;
   } border_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_GRAD,
      ST_LAUNCH,
      ST_WAIT,
      ST_HOLD
   } sem_state_type;

   typedef enum logic [1:0] {
      MAG_IDLE,
      MAG_ADD,
      MAG_ROOT,
      MAG_ROUND
   } mag_phase_type;

endpackage

// ===== sv/sem_stream_if.sv =====
// ----------------------------------------------------------------------------
// sem_stream_if
// Valid/ready channel carrying one payload per transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sem_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== sv/sobel_edge_magnitude_rgb_unit.sv =====
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_rgb_unit
// Streaming 3x3 Sobel edge magnitude on RGB pixels, per channel, zero border.
// Sequencing: an accepted item passes the read, gradient, launch and wait
//   states, or returns to idle after read if it yields no result; a result
//   is registered once all lanes finish and the result register is free.
//   Items are taken only in idle; each lane runs an eight-step square root.
// Reset: position counters and window cleared, geometry 640x480; the line
//   memory is not cleared and no clearing pass runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sobel_edge_magnitude_rgb_unit #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic          clock,
   input  logic          reset,
   sem_stream_if.sink    req,
   sem_stream_if.source  rsp,
   sem_stream_if.sink    csr
);
   import sem_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int XW = (CW + 1 > IMG_W_BITS) ? CW + 1 : IMG_W_BITS;
   localparam int RW = $clog2(MAX_HEIGHT + 2);
   localparam int YW = (RW + 1 > IMG_H_BITS + 1) ? RW + 1 : IMG_H_BITS + 1;

   // configuration
   logic [IMG_W_BITS-1:0] img_width_ff, img_width_in;
   logic [IMG_H_BITS-1:0] img_height_ff, img_height_in;

   // control
   sem_state_type state_ff, state_in;
   logic accept, in_ready, mem_wr, grad_ld, lane_start, rsp_load, slot_free;

   // position
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [XW-1:0] w_sat, col_a, col_b, q_col;
   logic [YW-1:0] h_sat, row_a, row_b, q_row;
   logic          has;
   border_type    border;
   logic          last;

   // current item
   logic [CW-1:0] item_addr_ff;
   rgb_type       item_pix_ff, pix_in;
   logic          item_has_ff;
   border_type    item_border_ff;
   logic          item_last_ff;

   // line memory: upper row in the high half, middle row in the low half
   logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
   logic [2*PIX_W-1:0] mem_rd_ff;

   // window and gradients
   rgb_type win_ff [TAPS];
   rgb_type win_in [TAPS];
   logic signed [GRAD_W-1:0] tap_val [CHAN_N][TAPS];
   logic signed [GRAD_W-1:0] grad_x_ff [CHAN_N];
   logic signed [GRAD_W-1:0] grad_x_in [CHAN_N];
   logic signed [GRAD_W-1:0] grad_y_ff [CHAN_N];
   logic signed [GRAD_W-1:0] grad_y_in [CHAN_N];

   logic [CHAN_N-1:0] lane_done;
   logic [CHAN_W-1:0] lane_mag [CHAN_N];
   logic              done_all;

   // result register
   logic        rsp_valid_ff, rsp_valid_in;
   sem_rsp_type rsp_data_ff, rsp_data_in;

   // ---------------- configuration port ----------------
   assign csr.ready = 1'b1;

   always_comb begin
      img_width_in  = img_width_ff;
      img_height_in = img_height_ff;
      if (csr.valid) begin
         unique case (csr.payload.index)
            REG_IMAGE_WIDTH:  img_width_in  = csr.payload.data[IMG_W_BITS-1:0];
            REG_IMAGE_HEIGHT: img_height_in = csr.payload.data[IMG_H_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- control ----------------
   assign accept    = req.valid && in_ready;
   assign req.ready = in_ready;
   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign done_all  = &lane_done;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = ST_READ;
         ST_READ:   state_in = item_has_ff ? ST_GRAD : ST_IDLE;
         ST_GRAD:   state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_WAIT;
         ST_WAIT:   if (done_all) state_in = slot_free ? ST_IDLE : ST_HOLD;
         ST_HOLD:   if (slot_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      in_ready   = 1'b0;
      mem_wr     = 1'b0;
      grad_ld    = 1'b0;
      lane_start = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         ST_IDLE:   in_ready   = 1'b1;
         ST_READ:   mem_wr     = 1'b1;
         ST_GRAD:   grad_ld    = 1'b1;
         ST_LAUNCH: lane_start = 1'b1;
         ST_WAIT:   rsp_load   = done_all && slot_free;
         ST_HOLD:   rsp_load   = slot_free;
         default: ;
      endcase
   end

   // ---------------- position and border flags ----------------
   always_comb begin
      w_sat = XW'(img_width_ff);
      if (w_sat == '0) begin
         w_sat = XW'(1);
      end else if (w_sat > XW'(MAX_WIDTH)) begin
         w_sat = XW'(MAX_WIDTH);
      end
      h_sat = YW'(img_height_ff);
      if (h_sat == '0) begin
         h_sat = YW'(1);
      end else if (h_sat > YW'(MAX_HEIGHT)) begin
         h_sat = YW'(MAX_HEIGHT);
      end
   end

   always_comb begin
      col_a = XW'(col_ff);
      row_a = YW'(row_ff);
      if (col_a >= w_sat) begin
         col_a = '0;
         row_a = row_a + YW'(1);
      end
      if (row_a > h_sat + YW'(1)) begin
         row_a = '0;
         col_a = '0;
      end

      has = (row_a >= YW'(2)) || (row_a == YW'(1) && col_a != '0);
      if (col_a != '0) begin
         q_row = row_a - YW'(1);
         q_col = col_a - XW'(1);
      end else begin
         q_row = (row_a >= YW'(2)) ? row_a - YW'(2) : '0;
         q_col = w_sat - XW'(1);
      end

      // flush row ends the frame
      col_b = '0;
      row_b = '0;
      if (row_a < h_sat + YW'(1)) begin
         col_b = col_a + XW'(1);
         row_b = row_a;
         if (col_b >= w_sat) begin
            col_b = '0;
            row_b = row_a + YW'(1);
         end
      end

      border.top    = q_row == '0;
      border.bottom = q_row + YW'(1) >= h_sat;
      border.left   = q_col == '0;
      border.right  = q_col + XW'(1) >= w_sat;
      last          = (q_row == h_sat - YW'(1)) && (q_col == w_sat - XW'(1));

      col_in = accept ? col_b[CW-1:0] : col_ff;
      row_in = accept ? row_b[RW-1:0] : row_ff;
   end

   assign pix_in = req.payload.flush ? '0
                 : {req.payload.blue_in, req.payload.green_in, req.payload.red_in};

   always_ff @(posedge clock) begin
      if (accept) begin
         item_addr_ff   <= col_a[CW-1:0];
         item_pix_ff    <= pix_in;
         item_has_ff    <= has;
         item_border_ff <= border;
         item_last_ff   <= last;
      end
   end

   // ---------------- line memory ----------------
   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rd_ff <= line_mem[col_a[CW-1:0]];
      end
      if (mem_wr) begin
         line_mem[item_addr_ff] <= {mem_rd_ff[PIX_W-1:0], item_pix_ff};
      end
   end

   // ---------------- window ----------------
   always_comb begin
      win_in = win_ff;
      if (mem_wr) begin
         for (int r = 0; r < WIN_N; r++) begin
            for (int c = 0; c < WIN_N - 1; c++) begin
               win_in[r*WIN_N + c] = win_ff[r*WIN_N + c + 1];
            end
         end
         win_in[WIN_N-1]       = rgb_type'(mem_rd_ff[2*PIX_W-1:PIX_W]);
         win_in[2*WIN_N-1]     = rgb_type'(mem_rd_ff[PIX_W-1:0]);
         win_in[WIN_N*WIN_N-1] = item_pix_ff;
      end
   end

   always_comb begin
      for (int r = 0; r < WIN_N; r++) begin
         for (int c = 0; c < WIN_N; c++) begin
            for (int ch = 0; ch < CHAN_N; ch++) begin
               if ((r == 0 && item_border_ff.top) || (r == WIN_N-1 && item_border_ff.bottom)
                   || (c == 0 && item_border_ff.left)
                   || (c == WIN_N-1 && item_border_ff.right)) begin
                  tap_val[ch][r*WIN_N + c] = '0;
               end else begin
                  tap_val[ch][r*WIN_N + c] = $signed(GRAD_W'(win_ff[r*WIN_N + c][ch]));
               end
            end
         end
      end
   end

   always_comb begin
      for (int ch = 0; ch < CHAN_N; ch++) begin
         grad_x_in[ch] = '0;
         grad_y_in[ch] = '0;
         for (int k = 0; k < TAPS; k++) begin
            grad_x_in[ch] = grad_x_in[ch] + tap_val[ch][k] * GRAD_W'(KERN_X[k]);
            grad_y_in[ch] = grad_y_in[ch] + tap_val[ch][k] * GRAD_W'(KERN_Y[k]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (grad_ld) begin
         grad_x_ff <= grad_x_in;
         grad_y_ff <= grad_y_in;
      end
   end

   // ---------------- channel lanes ----------------
   for (genvar ch = 0; ch < CHAN_N; ch++) begin : g_lane
      sem_mag u_mag (
         .clock  (clock),
         .reset  (reset),
         .start  (lane_start),
         .grad_x (grad_x_ff[ch]),
         .grad_y (grad_y_ff[ch]),
         .done   (lane_done[ch]),
         .mag    (lane_mag[ch])
      );
   end

   // ---------------- result register ----------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in           = 1'b1;
         rsp_data_in.red_out    = lane_mag[0];
         rsp_data_in.green_out  = lane_mag[1];
         rsp_data_in.blue_out   = lane_mag[2];
         rsp_data_in.frame_last = item_last_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         img_width_ff  <= IMG_W_RESET;
         img_height_ff <= IMG_H_RESET;
         state_ff      <= ST_IDLE;
         col_ff        <= '0;
         row_ff        <= '0;
         win_ff        <= '{default: '0};
         rsp_valid_ff  <= 1'b0;
      end else begin
         img_width_ff  <= img_width_in;
         img_height_ff <= img_height_in;
         state_ff      <= state_in;
         col_ff        <= col_in;
         row_ff        <= row_in;
         win_ff        <= win_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // ---------------- assertions ----------------
   a_lanes_lockstep: assert property (@(posedge clock) disable iff (reset)
      (lane_done != '0) |-> (&lane_done))
      else $error("channel lanes finished out of step");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      lane_done[0] |-> (state_ff == ST_WAIT))
      else $error("lane finished outside of wait state");

   a_result_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> item_has_ff)
      else $error("result loaded for an item without a neighborhood");

   a_row_bound: assert property (@(posedge clock) disable iff (reset)
      YW'(row_ff) <= YW'(MAX_HEIGHT + 1))
      else $error("row position beyond flush row");

endmodule

// ===== sv/sem_mag.sv =====
// ----------------------------------------------------------------------------
// sem_mag
// One channel lane: squares, sum, digit-by-digit square root, rounding, clamp.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sem_mag (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [sem_pkg::GRAD_W-1:0]  grad_x,
   input  logic signed [sem_pkg::GRAD_W-1:0]  grad_y,
   output logic                               done,
   output logic        [sem_pkg::CHAN_W-1:0]  mag
);
   import sem_pkg::*;

   localparam int ABS_W = GRAD_W - 1;
   localparam int SQ_W  = 2 * ABS_W;
   localparam int SUM_W = SQ_W + 1;
   localparam int RAD_W = 2 * CHAN_W;
   localparam int REM_W = CHAN_W + 3;
   localparam int CNT_W = $clog2(CHAN_W);
   localparam logic [SUM_W-1:0] SAT_SUM = SUM_W'(SAT_LIMIT);

   mag_phase_type phase_ff, phase_in;
   logic ld_sq, ld_sum, step, finish;

   logic signed [GRAD_W-1:0] neg_x, neg_y;
   logic [ABS_W-1:0] abs_x, abs_y;
   logic [SQ_W-1:0]  sq_x_ff, sq_x_in, sq_y_ff, sq_y_in;
   logic [SUM_W-1:0] sum;
   logic             sat_ff, sat_in;
   logic [RAD_W-1:0] sh_ff, sh_in;
   logic [REM_W-1:0] rem_ff, rem_in, rem_sh, trial;
   logic             fit;
   logic [CHAN_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [CHAN_W-1:0] mag_ff, mag_in;
   logic              done_ff, done_in;

   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         MAG_IDLE:  if (start) phase_in = MAG_ADD;
         MAG_ADD:   phase_in = MAG_ROOT;
         MAG_ROOT:  if (cnt_ff == CNT_W'(CHAN_W - 1)) phase_in = MAG_ROUND;
         MAG_ROUND: phase_in = MAG_IDLE;
         default:   phase_in = MAG_IDLE;
      endcase
   end

   always_comb begin
      ld_sq  = 1'b0;
      ld_sum = 1'b0;
      step   = 1'b0;
      finish = 1'b0;
      unique case (phase_ff)
         MAG_IDLE:  ld_sq  = start;
         MAG_ADD:   ld_sum = 1'b1;
         MAG_ROOT:  step   = 1'b1;
         MAG_ROUND: finish = 1'b1;
         default: ;
      endcase
   end

   assign neg_x  = -grad_x;
   assign neg_y  = -grad_y;
   assign abs_x  = grad_x[GRAD_W-1] ? neg_x[ABS_W-1:0] : grad_x[ABS_W-1:0];
   assign abs_y  = grad_y[GRAD_W-1] ? neg_y[ABS_W-1:0] : grad_y[ABS_W-1:0];
   assign sum    = SUM_W'(sq_x_ff) + SUM_W'(sq_y_ff);
   assign rem_sh = {rem_ff[REM_W-3:0], sh_ff[RAD_W-1 -: 2]};
   assign trial  = REM_W'({root_ff, 2'b01});
   assign fit    = rem_sh >= trial;

   always_comb begin
      sq_x_in = sq_x_ff;
      sq_y_in = sq_y_ff;
      sat_in  = sat_ff;
      sh_in   = sh_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      mag_in  = mag_ff;
      done_in = finish;
      if (ld_sq) begin
         sq_x_in = SQ_W'(abs_x) * SQ_W'(abs_x);
         sq_y_in = SQ_W'(abs_y) * SQ_W'(abs_y);
      end
      if (ld_sum) begin
         sat_in  = sum > SAT_SUM;
         sh_in   = sum[RAD_W-1:0];
         rem_in  = '0;
         root_in = '0;
         cnt_in  = '0;
      end
      if (step) begin
         sh_in   = {sh_ff[RAD_W-3:0], 2'b00};
         rem_in  = fit ? rem_sh - trial : rem_sh;
         root_in = {root_ff[CHAN_W-2:0], fit};
         cnt_in  = cnt_ff + CNT_W'(1);
      end
      if (finish) begin
         // round half up: remainder above root means s > n*n + n
         if (sat_ff) begin
            mag_in = '1;
         end else if (rem_ff > REM_W'(root_ff)) begin
            mag_in = root_ff + CHAN_W'(1);
         end else begin
            mag_in = root_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= MAG_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         done_ff  <= done_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_x_ff <= sq_x_in;
      sq_y_ff <= sq_y_in;
      sat_ff  <= sat_in;
      sh_ff   <= sh_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      mag_ff  <= mag_in;
   end

   assign done = done_ff;
   assign mag  = mag_ff;

endmodule
